// ----- hdl/interval_time_histogram_defines.svh -----
// Assertion macros shared by the histogram RTL
`ifndef INTERVAL_TIME_HISTOGRAM_DEFINES_SVH
`define INTERVAL_TIME_HISTOGRAM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ITH_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ITH_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ith_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval time histogram package
// Request codes, time constants, sequencer states and saturating adders.
// ----------------------------------------------------------------------------
package ith_pkg;

   localparam logic [2:0] REQ_ADD   = 3'd0;
   localparam logic [2:0] REQ_HOUR  = 3'd1;
   localparam logic [2:0] REQ_WDAY  = 3'd2;
   localparam logic [2:0] REQ_DAY   = 3'd3;
   localparam logic [2:0] REQ_TOTAL = 3'd4;
   localparam logic [2:0] REQ_CLEAR = 3'd5;

   localparam logic [11:0] SEC_HOUR   = 12'd3600;
   localparam logic [16:0] DAY_2010   = 17'd14610;  // 2010-01-01 in days since 1970
   localparam logic [16:0] WDAY_OFS   = 17'd4;      // 1970-01-01 was a Thursday
   localparam int          HOUR_BINS  = 24;
   localparam int          WDAY_BINS  = 7;

   // reciprocal and back-multiply factors for the start time split
   localparam logic [25:0] RCP_DAY    = 26'd50903317; // ceil(2^35 / 675), on start >> 7
   localparam logic [25:0] MUL_DAY    = 26'd86400;
   localparam logic [25:0] RCP_HOUR   = 26'd9321;     // ceil(2^21 / 225), on seconds >> 4
   localparam logic [25:0] MUL_HOUR   = 26'd3600;
   localparam logic [25:0] RCP_WDAY   = 26'd74899;    // ceil(2^19 / 7)
   localparam logic [25:0] MUL_WDAY   = 26'd7;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_SEG_RD, ST_SEG_WR, ST_RD_WAIT, ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      PH_DAY_Q, PH_DAY_R, PH_HOUR_Q, PH_HOUR_R, PH_WDAY_Q, PH_WDAY_R
   } phase_type;

   // 32-bit bin plus one segment, clamped
   function automatic logic [31:0] sat32(logic [31:0] a, logic [11:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {21'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // 40-bit total plus one interval length, clamped
   function automatic logic [39:0] sat40(logic [39:0] a, logic [31:0] b);
      logic [40:0] s;
      s = {1'b0, a} + {9'd0, b};
      return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
   endfunction

endpackage

// ----- hdl/interval_time_histogram.sv -----
// Add: splits the start time on one shared multiplier (six
//   multiply-and-reduce steps, each a multiply then a reduce), then a day bin
//   read-modify-write per hour piece (ST_SEG_RD, ST_SEG_WR), then the response beat.
// Reads and empty add: straight to response; day bin via ST_RD_WAIT (registered read).
// Clear: sweeps the day bin memory, then the response beat.
// Reset: synchronous; runs the same sweep with no response beat.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval time histogram
// Splits stays at hour and day boundaries into hour, weekday and day bins.
// ----------------------------------------------------------------------------
`include "interval_time_histogram_defines.svh"

module interval_time_histogram #(
   parameter int DAY_COUNT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // start_time[31:0], end_time[63:32], bin_index[75:64]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value[39:0]
   output logic        rsp_tuser    // index_invalid[0]
);
   import ith_pkg::*;

   localparam int IDX_W = $clog2(DAY_COUNT);

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [31:0]         hour_bins_ff [HOUR_BINS];
   logic [31:0]         hour_bins_in [HOUR_BINS];
   logic [31:0]         wday_bins_ff [WDAY_BINS];
   logic [31:0]         wday_bins_in [WDAY_BINS];
   logic [39:0]         total_ff, total_in;
   logic [IDX_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                clr_rsp_ff, clr_rsp_in;
   logic [31:0]         div_num_ff, div_num_in;
   logic [24:0]         mul_a_ff, mul_a_in;
   logic [50:0]         mul_p_ff, mul_p_in;
   logic                mul_hold_ff, mul_hold_in;
   logic [31:0]         remain_ff, remain_in;
   logic [11:0]         to_bnd_ff, to_bnd_in;
   logic [4:0]          hour_ff, hour_in;
   logic [2:0]          wday_ff, wday_in;
   logic [16:0]         day_ff, day_in;
   logic [39:0]         rsp_val_ff, rsp_val_in;
   logic                rsp_bad_ff, rsp_bad_in;

   logic [31:0]         day_mem [DAY_COUNT];
   logic [31:0]         mem_rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr, mem_raddr;
   logic [31:0]         mem_wdata;

   logic [2:0]          req_kind;
   logic [31:0]         req_start, req_end;
   logic [11:0]         req_bin;
   logic [IDX_W-1:0]    req_idx;
   logic                req_fire;
   logic [4:0]          hb_raddr;
   logic [2:0]          wb_raddr;
   logic [25:0]         mul_b;
   logic [50:0]         mul_prod;
   logic [31:0]         rem_dif;
   logic [16:0]         day_wofs, wd_dif;
   logic [17:0]         day_rel;
   logic                day_ok;
   logic [IDX_W-1:0]    day_idx;
   logic [11:0]         seg;

   // request fields
   assign req_kind  = req_tuser;
   assign req_start = req_tdata[31:0];
   assign req_end   = req_tdata[63:32];
   assign req_bin   = req_tdata[75:64];
   assign req_idx   = IDX_W'(req_bin);
   assign req_fire  = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // shared multiplier: reciprocal for a quotient, constant for the remainder
   always_comb begin
      unique case (phase_ff)
         PH_DAY_Q:  mul_b = RCP_DAY;
         PH_DAY_R:  mul_b = MUL_DAY;
         PH_HOUR_Q: mul_b = RCP_HOUR;
         PH_HOUR_R: mul_b = MUL_HOUR;
         PH_WDAY_Q: mul_b = RCP_WDAY;
         default:   mul_b = MUL_WDAY;
      endcase
      mul_prod = 51'(mul_a_ff) * 51'(mul_b);
   end

   // remainders from the registered product
   assign rem_dif  = div_num_ff - mul_p_ff[31:0];
   assign day_wofs = day_ff + WDAY_OFS;
   assign wd_dif   = day_wofs - mul_p_ff[16:0];

   // day bin address, out-of-range days fold into bin 0
   assign day_rel = {1'b0, day_ff} - {1'b0, DAY_2010};
   assign day_ok  = (day_ff >= DAY_2010) && (day_rel < 18'(DAY_COUNT));
   assign day_idx = day_ok ? IDX_W'(day_rel) : '0;

   // current hour piece length
   assign seg = (remain_ff < {20'd0, to_bnd_ff}) ? remain_ff[11:0] : to_bnd_ff;

   // shared read ports
   assign hb_raddr  = (state_ff == ST_IDLE) ? req_bin[4:0] : hour_ff;
   assign wb_raddr  = (state_ff == ST_IDLE) ? req_bin[2:0] : wday_ff;
   assign mem_raddr = (state_ff == ST_IDLE) ? req_idx : day_idx;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      hour_bins_in = hour_bins_ff;
      wday_bins_in = wday_bins_ff;
      total_in     = total_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      div_num_in   = div_num_ff;
      mul_a_in     = mul_a_ff;
      mul_p_in     = mul_p_ff;
      mul_hold_in  = mul_hold_ff;
      remain_in    = remain_ff;
      to_bnd_in    = to_bnd_ff;
      hour_in      = hour_ff;
      wday_in      = wday_ff;
      day_in       = day_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_bad_in   = rsp_bad_ff;
      mem_we       = 1'b0;
      mem_waddr    = day_idx;
      mem_wdata    = sat32(mem_rd_ff, seg);

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IDX_W'(DAY_COUNT - 1)) begin
               state_in = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               rsp_val_in = '0;
               rsp_bad_in = 1'b0;
               state_in   = ST_RESP;
               case (req_kind)
                  REQ_ADD: begin
                     if (req_end > req_start) begin
                        total_in    = sat40(total_ff, req_end - req_start);
                        remain_in   = req_end - req_start;
                        div_num_in  = req_start;
                        mul_a_in    = req_start[31:7];
                        mul_hold_in = 1'b0;
                        phase_in    = PH_DAY_Q;
                        state_in    = ST_DIV;
                     end
                  end
                  REQ_HOUR: begin
                     if (req_bin < 12'(HOUR_BINS)) rsp_val_in = {8'd0, hour_bins_ff[hb_raddr]};
                     else rsp_bad_in = 1'b1;
                  end
                  REQ_WDAY: begin
                     if (req_bin < 12'(WDAY_BINS)) rsp_val_in = {8'd0, wday_bins_ff[wb_raddr]};
                     else rsp_bad_in = 1'b1;
                  end
                  REQ_DAY: begin
                     if (32'(req_bin) < 32'(DAY_COUNT)) state_in = ST_RD_WAIT;
                     else rsp_bad_in = 1'b1;
                  end
                  REQ_TOTAL: rsp_val_in = total_ff;
                  REQ_CLEAR: begin
                     for (int i = 0; i < HOUR_BINS; i++) hour_bins_in[i] = '0;
                     for (int i = 0; i < WDAY_BINS; i++) wday_bins_in[i] = '0;
                     total_in   = '0;
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         // split the start time: register the product, then reduce it the next cycle
         ST_DIV: begin
            if (!mul_hold_ff) begin
               mul_p_in    = mul_prod;
               mul_hold_in = 1'b1;
            end else begin
               mul_hold_in = 1'b0;
               unique case (phase_ff)
                  PH_DAY_Q: begin
                     day_in   = {1'b0, mul_p_ff[50:35]};
                     mul_a_in = {9'd0, mul_p_ff[50:35]};
                     phase_in = PH_DAY_R;
                  end
                  PH_DAY_R: begin
                     // seconds into the day
                     div_num_in = rem_dif;
                     mul_a_in   = {12'd0, rem_dif[16:4]};
                     phase_in   = PH_HOUR_Q;
                  end
                  PH_HOUR_Q: begin
                     hour_in  = mul_p_ff[25:21];
                     mul_a_in = {20'd0, mul_p_ff[25:21]};
                     phase_in = PH_HOUR_R;
                  end
                  PH_HOUR_R: begin
                     to_bnd_in = SEC_HOUR - rem_dif[11:0];
                     mul_a_in  = {8'd0, day_wofs};
                     phase_in  = PH_WDAY_Q;
                  end
                  PH_WDAY_Q: begin
                     mul_a_in = {12'd0, mul_p_ff[31:19]};
                     phase_in = PH_WDAY_R;
                  end
                  default: begin
                     wday_in  = wd_dif[2:0];
                     state_in = ST_SEG_RD;
                  end
               endcase
            end
         end
         ST_SEG_RD: state_in = ST_SEG_WR;
         ST_SEG_WR: begin
            hour_bins_in[hour_ff] = sat32(hour_bins_ff[hb_raddr], seg);
            wday_bins_in[wday_ff] = sat32(wday_bins_ff[wb_raddr], seg);
            mem_we    = 1'b1;
            remain_in = remain_ff - {20'd0, seg};
            // crossed an hour boundary
            if (seg == to_bnd_ff) begin
               to_bnd_in = SEC_HOUR;
               if (hour_ff == 5'(HOUR_BINS - 1)) begin
                  hour_in = '0;
                  day_in  = day_ff + 1'b1;
                  wday_in = (wday_ff == 3'(WDAY_BINS - 1)) ? 3'd0 : wday_ff + 1'b1;
               end else begin
                  hour_in = hour_ff + 1'b1;
               end
            end
            state_in = (remain_ff == {20'd0, seg}) ? ST_RESP : ST_SEG_RD;
         end
         ST_RD_WAIT: begin
            rsp_val_in = {8'd0, mem_rd_ff};
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         total_ff   <= '0;
         for (int i = 0; i < HOUR_BINS; i++) hour_bins_ff[i] <= '0;
         for (int i = 0; i < WDAY_BINS; i++) wday_bins_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         total_ff     <= total_in;
         hour_bins_ff <= hour_bins_in;
         wday_bins_ff <= wday_bins_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      div_num_ff  <= div_num_in;
      mul_a_ff    <= mul_a_in;
      mul_p_ff    <= mul_p_in;
      mul_hold_ff <= mul_hold_in;
      remain_ff   <= remain_in;
      to_bnd_ff   <= to_bnd_in;
      hour_ff     <= hour_in;
      wday_ff     <= wday_in;
      day_ff      <= day_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // day bin memory
   always_ff @(posedge clock) begin
      if (mem_we) day_mem[mem_waddr] <= mem_wdata;
      mem_rd_ff <= day_mem[mem_raddr];
   end

   // checks
   `ITH_ASSERT_IMP(a_one_side, req_tready, !rsp_tvalid, "accepting while a beat waits")
   `ITH_ASSERT_IMP(a_bad_zero, rsp_tvalid && rsp_tuser, rsp_tdata == 40'd0, "invalid index with data")
   `ITH_ASSERT_IMP(a_seg_live, state_ff == ST_SEG_WR, seg != 12'd0 && to_bnd_ff <= SEC_HOUR, "empty hour piece")
   `ITH_ASSERT_NXT(a_clear_go, req_fire && req_kind == REQ_CLEAR, state_ff == ST_CLEAR, "clear not started")

endmodule

// ----- bench/interval_time_histogram_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval time histogram testbench
// Drives add, read, clear and unknown requests through the stream ports. A
// directed table comes first, then random requests, with idling on both sides.
// Every response beat is compared with a local model of the bins or its row's value.
// ----------------------------------------------------------------------------
module interval_time_histogram_tb;
   import ith_pkg::*;

   localparam int          DAYS       = 4096;
   localparam int          RAND_ITEMS = 1530;
   localparam int          STALL_MAX  = 40000;
   localparam longint      SEC_H      = 3600;
   localparam longint      SEC_D      = 86400;
   localparam longint      EPOCH10    = 1262304000;
   localparam logic [2:0]  REQ_BAD6   = 3'd6;
   localparam logic [2:0]  REQ_BAD7   = 3'd7;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] t_start;
      logic [31:0] t_end;
      logic [11:0] idx;
      bit          typed;      // response value given in the row
      logic [39:0] val;
      bit          bad;
   } stim_row;

   typedef struct {
      logic [39:0] val;
      bit          bad;
   } rsp_beat;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // start_time[31:0], end_time[63:32], bin_index[75:64]
   logic [2:0]  req_tuser = '0;   // req_type[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // read_value[39:0]
   logic        rsp_tuser;        // index_invalid[0]

   // local copy of the histogram
   bit [31:0] hour_sec [24];
   bit [31:0] wday_sec [7];
   bit [31:0] day_sec  [DAYS];
   bit [39:0] total_sec;

   rsp_beat   pending_rsp[$];
   int        fails = 0;
   int        idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
   int        quiet_cycles = 0;
   int        last_day = 0;
   stim_row   table_rows[$];

   interval_time_histogram #(.DAY_COUNT(DAYS)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit [31:0] clamp_add(bit [31:0] a, longint unsigned b);
      longint unsigned s;
      if (b >= 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      s = longint'(a) + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void clear_bins();
      foreach (hour_sec[k]) hour_sec[k] = '0;
      foreach (wday_sec[k]) wday_sec[k] = '0;
      foreach (day_sec[k]) day_sec[k] = '0;
      total_sec = '0;
   endfunction

   // append one row to the directed table
   function automatic void add_row(stim_row r);
      table_rows = {table_rows, r};
   endfunction

   // split one stay into hour, weekday and day pieces
   function automatic void book_stay(longint unsigned s, longint unsigned e);
      longint unsigned h0, h1, n, c, r, h, d, lo, hi, ix;
      longint unsigned t;
      h0 = s / SEC_H;
      h1 = e / SEC_H;
      if (h0 == h1) begin
         hour_sec[h0 % 24] = clamp_add(hour_sec[h0 % 24], e - s);
      end else begin
         hour_sec[h0 % 24] = clamp_add(hour_sec[h0 % 24], (h0 + 1) * SEC_H - s);
         hour_sec[h1 % 24] = clamp_add(hour_sec[h1 % 24], e - h1 * SEC_H);
         n = h1 - h0 - 1;
         c = n / 24;
         r = n % 24;
         if (c > 0)
            for (int k = 0; k < 24; k++) hour_sec[k] = clamp_add(hour_sec[k], c * SEC_H);
         h = (h0 + 1) % 24;
         for (longint unsigned k = 0; k < r; k++) begin
            hour_sec[h] = clamp_add(hour_sec[h], SEC_H);
            h = (h + 1) % 24;
         end
      end
      for (d = s / SEC_D; d <= e / SEC_D; d++) begin
         lo = d * SEC_D;
         hi = lo + SEC_D;
         if (lo < s) lo = s;
         if (hi > e) hi = e;
         if (hi > lo) begin
            wday_sec[(d + 4) % 7] = clamp_add(wday_sec[(d + 4) % 7], hi - lo);
            ix = 0;
            if (d >= EPOCH10 / SEC_D && d - EPOCH10 / SEC_D < DAYS) ix = d - EPOCH10 / SEC_D;
            day_sec[ix] = clamp_add(day_sec[ix], hi - lo);
         end
      end
      t = longint'(total_sec) + (e - s);
      total_sec = (t > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : t[39:0];
   endfunction

   // apply one accepted request, return its response
   function automatic rsp_beat histogram_step(stim_row it);
      rsp_beat b;
      b.val = '0;
      b.bad = 1'b0;
      case (it.kind)
         REQ_ADD: if (it.t_end > it.t_start) book_stay(it.t_start, it.t_end);
         REQ_HOUR: if (it.idx < 24) b.val = hour_sec[it.idx]; else b.bad = 1'b1;
         REQ_WDAY: if (it.idx < 7) b.val = wday_sec[it.idx]; else b.bad = 1'b1;
         REQ_DAY: if (it.idx < DAYS) b.val = day_sec[it.idx]; else b.bad = 1'b1;
         REQ_TOTAL: b.val = total_sec;
         REQ_CLEAR: clear_bins();
         default: ;
      endcase
      return b;
   endfunction

   // send one beat, honoring the sender idle mode
   task automatic send_item(stim_row it);
      rsp_beat b;
      if (idle_mode == 1 || idle_mode == 3) begin
         while ($urandom_range(99) < ((idle_mode == 1) ? 56 : 12)) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, it.idx, it.t_end, it.t_start};
      req_tuser  <= it.kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      b = histogram_step(it);
      if (it.typed) begin
         b.val = it.val;
         b.bad = it.bad;
      end
      pending_rsp = {pending_rsp, b};
   endtask

   function automatic stim_row mk(logic [2:0] kind, logic [31:0] s, logic [31:0] e,
                                  logic [11:0] idx, bit typed, logic [39:0] val, bit bad);
      stim_row r;
      r.kind = kind; r.t_start = s; r.t_end = e; r.idx = idx;
      r.typed = typed; r.val = val; r.bad = bad;
      return r;
   endfunction

   function automatic stim_row random_item();
      stim_row r;
      int      pick;
      longint unsigned s, len, e;
      r = mk(REQ_ADD, 0, 0, 0, 0, 0, 0);
      pick = $urandom_range(99);
      if (pick < 50) begin
         if ($urandom_range(99) < 80)
            s = EPOCH10 + $urandom_range(DAYS * 86400 + 20 * 86400);
         else
            s = $urandom;
         pick = $urandom_range(99);
         if (pick < 4) len = 0;
         else if (pick < 85) len = $urandom_range(7200);
         else if (pick < 98) len = $urandom_range(3 * 86400);
         else len = $urandom_range(30 * 86400);
         e = s + len;
         if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
         if ($urandom_range(99) < 3) e = s - $urandom_range(s < 5000 ? s : 5000);
         r.t_start = s[31:0];
         r.t_end   = e[31:0];
         if (s >= EPOCH10) last_day = (s - EPOCH10) / SEC_D;
      end else if (pick < 90) begin
         r.kind = REQ_HOUR + $urandom_range(2);
         if ($urandom_range(9) == 0) r.idx = $urandom;
         else if (r.kind == REQ_HOUR) r.idx = $urandom_range(25);
         else if (r.kind == REQ_WDAY) r.idx = $urandom_range(7);
         else r.idx = ($urandom_range(1) != 0 && last_day < DAYS) ?
                      last_day + $urandom_range(1) : $urandom_range(DAYS - 1);
         r.t_start = $urandom;
         r.t_end   = $urandom;
      end else if (pick < 95) begin
         r.kind = REQ_TOTAL;
         r.idx  = $urandom;
      end else if (pick < 97) begin
         r.kind = REQ_CLEAR;
      end else begin
         r.kind = ($urandom_range(1) != 0) ? REQ_BAD6 : REQ_BAD7;
         r.t_start = $urandom;
         r.t_end   = $urandom;
         r.idx     = $urandom;
      end
      return r;
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      if (idle_mode == 2) rsp_tready <= ($urandom_range(99) >= 56);
      else if (idle_mode == 3) rsp_tready <= ($urandom_range(99) >= 12);
      else rsp_tready <= 1'b1;
   end

   // response checker
   always @(posedge clock) begin
      rsp_beat want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing expected, value %h invalid %b",
                     $time, rsp_tdata, rsp_tuser);
            fails++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata !== want.val) begin
               $display("%0t: read_value expected %h actual %h", $time, want.val, rsp_tdata);
               fails++;
            end
            if (rsp_tuser !== want.bad) begin
               $display("%0t: index_invalid expected %b actual %b", $time, want.bad, rsp_tuser);
               fails++;
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      clear_bins();
      // after reset, extremes, invalid indices, unknown requests
      add_row(mk(REQ_HOUR,  0, 0, 12'd0,    1, 40'd0, 0));
      add_row(mk(REQ_HOUR,  0, 0, 12'd23,   1, 40'd0, 0));
      add_row(mk(REQ_HOUR,  0, 0, 12'd24,   1, 40'd0, 1));
      add_row(mk(REQ_WDAY,  0, 0, 12'd6,    1, 40'd0, 0));
      add_row(mk(REQ_WDAY,  0, 0, 12'd7,    1, 40'd0, 1));
      add_row(mk(REQ_DAY,   0, 0, 12'd4095, 1, 40'd0, 0));
      add_row(mk(REQ_HOUR,  0, 0, 12'hFFF,  1, 40'd0, 1));
      add_row(mk(REQ_TOTAL, '1, '1, 12'hFFF, 1, 40'd0, 0));
      add_row(mk(REQ_BAD6,  '1, '1, 12'hFFF, 1, 40'd0, 0));
      add_row(mk(REQ_BAD7,  '1, 0, 12'd3,    1, 40'd0, 0));
      // empty stays add nothing
      add_row(mk(REQ_ADD, 32'd100, 32'd100, 0, 1, 40'd0, 0));
      add_row(mk(REQ_ADD, 32'd200, 32'd100, 0, 1, 40'd0, 0));
      add_row(mk(REQ_TOTAL, 0, 0, 0, 1, 40'd0, 0));
      // stays across hour and day edges, before 2010, past the store, on a boundary
      add_row(mk(REQ_ADD, 1262304000 + 3000, 1262304000 + 2 * 86400 + 5000,
                 0, 1, 40'd0, 0));
      add_row(mk(REQ_ADD, 32'd0, 32'd5000, 0, 1, 40'd0, 0));
      add_row(mk(REQ_ADD, 32'hFFFF_F000, 32'hFFFF_FFFF, 0, 1, 40'd0, 0));
      add_row(mk(REQ_ADD, 1262304000 + 3500, 1262304000 + 3600, 0, 1, 40'd0, 0));
      add_row(mk(REQ_HOUR,  0, 0, 12'd0, 0, 0, 0));
      add_row(mk(REQ_HOUR,  0, 0, 12'd23, 0, 0, 0));
      add_row(mk(REQ_WDAY,  0, 0, 12'd4, 0, 0, 0));
      add_row(mk(REQ_DAY,   0, 0, 12'd0, 0, 0, 0));
      add_row(mk(REQ_DAY,   0, 0, 12'd2, 0, 0, 0));
      add_row(mk(REQ_TOTAL, 0, 0, 0, 0, 0, 0));
      add_row(mk(REQ_CLEAR, 0, 0, 0, 1, 40'd0, 0));
      add_row(mk(REQ_TOTAL, 0, 0, 0, 1, 40'd0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (table_rows[k]) send_item(table_rows[k]);

      // random part, idling mode changes every hundred beats
      for (int k = 0; k < RAND_ITEMS; k++) begin
         idle_mode = (k / 100) % 4;
         send_item(random_item());
      end
      req_tvalid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fails == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
